// File: rtl/cau_pkg.sv
// Package: command codes and shared types for the complex arithmetic unit.
`default_nettype none
package cau_pkg;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_EQ  = 3'd4
    } cmd_t;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned PROD_W = 64;
    localparam int unsigned SUM_W  = 65;
    localparam int unsigned DEN_W  = 64;

    // Per-item control carried alongside the data.
    typedef struct packed {
        logic [2:0] cmd;
        logic       dz;
        logic       eq;
    } ctl_t;

endpackage
`default_nettype wire

// File: rtl/complex_arith_unit.sv
// Top level: pipelined complex add, subtract, multiply, divide and compare in signed fixed point.
//
// channel  | handshake        | payload
// ---------+------------------+--------------------------------------------------
// input    | start / busy     | command, a_real, a_imag, b_real, b_imag
// result   | done (strobe)    | result_real, result_imag, equal, divide_by_zero
//
// One item a cycle; busy is held low. Every command's result passes two product
// stages, then a delay matching the one-bit-per-stage divider (33 quotient
// stages plus input, setup and output registers, 36 in all).
// Results keep item order. Reset clears only the valid bits; the result side
// cannot stall.
`default_nettype none
module complex_arith_unit #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [2:0]          command,
    input  wire logic signed [31:0]  a_real,
    input  wire logic signed [31:0]  a_imag,
    input  wire logic signed [31:0]  b_real,
    input  wire logic signed [31:0]  b_imag,
    output logic                     done,
    output logic signed [31:0]       result_real,
    output logic signed [31:0]       result_imag,
    output logic                     equal,
    output logic                     divide_by_zero
);
    localparam int unsigned DW  = cau_pkg::DATA_W;
    localparam int unsigned LAT = DW + 4;   // divider latency

    cau_pkg::ctl_t in_ctl;
    logic          acc;
    assign busy = 1'b0;
    assign acc  = start & ~busy;

    always_comb
    begin
        in_ctl.cmd = command;
        in_ctl.dz  = (command == cau_pkg::CMD_DIV) && (b_real == '0) && (b_imag == '0);
        in_ctl.eq  = (command == cau_pkg::CMD_EQ) && (a_real == b_real) && (a_imag == b_imag);
    end

    logic                              m_valid;
    cau_pkg::ctl_t                     m_ctl;
    logic signed [cau_pkg::SUM_W-1:0]  num_re, num_im;
    logic        [cau_pkg::DEN_W-1:0]  den;
    logic signed [DW-1:0]              s_re, s_im;

    cau_mult #(.FRAC_BITS(FRAC_BITS)) u_mult (
        .clk(clk), .rst_n(rst_n), .in_valid(acc), .in_ctl(in_ctl),
        .ar(a_real), .ai(a_imag), .br(b_real), .bi(b_imag),
        .out_valid(m_valid), .out_ctl(m_ctl), .num_re(num_re), .num_im(num_im),
        .den(den), .simple_re(s_re), .simple_im(s_im)
    );

    // Multiply result: floor shift and saturate.
    function automatic logic signed [DW-1:0] mul_out(input logic signed [cau_pkg::SUM_W-1:0] v);
        logic signed [cau_pkg::SUM_W-1:0] sh;
        sh = v >>> FRAC_BITS;
        if (sh > cau_pkg::SUM_W'(signed'({1'b0, {(DW-1){1'b1}}})))
            mul_out = {1'b0, {(DW-1){1'b1}}};
        else if (sh < -(cau_pkg::SUM_W'(64'sh8000_0000)))
            mul_out = {1'b1, {(DW-1){1'b0}}};
        else
            mul_out = sh[DW-1:0];
    endfunction

    logic [cau_pkg::DEN_W-1:0] den_safe;
    assign den_safe = (den == '0) ? cau_pkg::DEN_W'(1) : den;

    logic signed [DW-1:0] q_re, q_im;
    logic                 q_v, q_v2;

    cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_re (
        .clk(clk), .rst_n(rst_n), .in_valid(m_valid), .num(num_re), .den(den_safe),
        .out_valid(q_v), .quo(q_re)
    );
    cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_im (
        .clk(clk), .rst_n(rst_n), .in_valid(m_valid), .num(num_im), .den(den_safe),
        .out_valid(q_v2), .quo(q_im)
    );

    // Delay line for the non-divide results, matching divider latency.
    cau_pkg::ctl_t        dc_reg [LAT];
    logic signed [DW-1:0] dre_reg[LAT];
    logic signed [DW-1:0] dim_reg[LAT];

    always_ff @(posedge clk)
    begin
        dc_reg[0] <= m_ctl;
        if (m_ctl.cmd == cau_pkg::CMD_MUL)
        begin
            dre_reg[0] <= mul_out(num_re);
            dim_reg[0] <= mul_out(num_im);
        end
        else
        begin
            dre_reg[0] <= s_re;
            dim_reg[0] <= s_im;
        end
        for (int i = 1; i < LAT; i++)
        begin
            dc_reg[i]  <= dc_reg[i-1];
            dre_reg[i] <= dre_reg[i-1];
            dim_reg[i] <= dim_reg[i-1];
        end
    end

    cau_pkg::ctl_t fc;
    assign fc = dc_reg[LAT-1];

    always_comb
    begin
        equal          = fc.eq;
        divide_by_zero = fc.dz;
        result_real    = '0;
        result_imag    = '0;
        case (fc.cmd)
            cau_pkg::CMD_ADD, cau_pkg::CMD_SUB, cau_pkg::CMD_MUL:
            begin
                result_real = dre_reg[LAT-1];
                result_imag = dim_reg[LAT-1];
            end
            cau_pkg::CMD_DIV:
            begin
                if (!fc.dz)
                begin
                    result_real = q_re;
                    result_imag = q_im;
                end
            end
            default:
            begin
                result_real = '0;
                result_imag = '0;
            end
        endcase
    end

    assign done = q_v;

    property p_lanes_aligned;
        @(posedge clk) disable iff (!rst_n) q_v == q_v2;
    endproperty
    a_lanes_aligned: assert property (p_lanes_aligned) else $error("divider lanes out of step");

    property p_flags_exclusive;
        @(posedge clk) disable iff (!rst_n) done |-> !(equal && divide_by_zero);
    endproperty
    a_flags_exclusive: assert property (p_flags_exclusive) else $error("both flags set");

    property p_dz_zero;
        @(posedge clk) disable iff (!rst_n)
            (done && divide_by_zero) |-> (result_real == '0 && result_imag == '0);
    endproperty
    a_dz_zero: assert property (p_dz_zero) else $error("nonzero result on zero divisor");
endmodule
`default_nettype wire

// File: rtl/cau_mult.sv
// Multiply stages: operand products, cross sums, the multiply or divide numerators, the divisor and add/sub sums.
`default_nettype none
module cau_mult #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    input  wire cau_pkg::ctl_t                         in_ctl,
    input  wire logic signed [cau_pkg::DATA_W-1:0]     ar,
    input  wire logic signed [cau_pkg::DATA_W-1:0]     ai,
    input  wire logic signed [cau_pkg::DATA_W-1:0]     br,
    input  wire logic signed [cau_pkg::DATA_W-1:0]     bi,
    output logic                                       out_valid,
    output cau_pkg::ctl_t                              out_ctl,
    output logic signed [cau_pkg::SUM_W-1:0]           num_re,
    output logic signed [cau_pkg::SUM_W-1:0]           num_im,
    output logic        [cau_pkg::DEN_W-1:0]           den,
    output logic signed [cau_pkg::DATA_W-1:0]          simple_re,
    output logic signed [cau_pkg::DATA_W-1:0]          simple_im
);
    localparam int unsigned PW = cau_pkg::PROD_W;
    localparam int unsigned SW = cau_pkg::SUM_W;
    localparam int unsigned DW = cau_pkg::DATA_W;
    localparam int unsigned DEN_W_L = cau_pkg::DEN_W;

    logic                 v1_reg, v2_reg;
    cau_pkg::ctl_t        c1_reg, c2_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic        [PW-1:0] p_bb_reg, p_cc_reg;
    logic signed [DW:0]   s_re_reg, s_im_reg;
    logic signed [SW-1:0] n_re_reg, n_im_reg;
    logic        [DEN_W_L-1:0] den_reg;
    logic signed [DW:0]   s2_re_reg, s2_im_reg;

    logic signed [SW-1:0] mre_next, mim_next, dre_next, dim_next;
    logic signed [DW:0]   s_re_next, s_im_next;

    always_comb
    begin
        s_re_next = '0;
        s_im_next = '0;
        if (in_ctl.cmd == cau_pkg::CMD_ADD)
        begin
            s_re_next = {ar[DW-1], ar} + {br[DW-1], br};
            s_im_next = {ai[DW-1], ai} + {bi[DW-1], bi};
        end
        else if (in_ctl.cmd == cau_pkg::CMD_SUB)
        begin
            s_re_next = {ar[DW-1], ar} - {br[DW-1], br};
            s_im_next = {ai[DW-1], ai} - {bi[DW-1], bi};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c1_reg   <= in_ctl;
        p_rr_reg <= ar * br;
        p_ii_reg <= ai * bi;
        p_ri_reg <= ar * bi;
        p_ir_reg <= ai * br;
        p_bb_reg <= br * br;
        p_cc_reg <= bi * bi;
        s_re_reg <= s_re_next;
        s_im_reg <= s_im_next;
    end

    always_comb
    begin
        mre_next = SW'(p_rr_reg) - SW'(p_ii_reg);
        mim_next = SW'(p_ri_reg) + SW'(p_ir_reg);
        dre_next = SW'(p_rr_reg) + SW'(p_ii_reg);
        dim_next = SW'(p_ir_reg) - SW'(p_ri_reg);
    end

    always_ff @(posedge clk)
    begin
        c2_reg    <= c1_reg;
        den_reg   <= DEN_W_L'(p_bb_reg + p_cc_reg);
        s2_re_reg <= s_re_reg;
        s2_im_reg <= s_im_reg;
        if (c1_reg.cmd == cau_pkg::CMD_MUL)
        begin
            n_re_reg <= mre_next;
            n_im_reg <= mim_next;
        end
        else
        begin
            n_re_reg <= dre_next;
            n_im_reg <= dim_next;
        end
    end

    function automatic logic signed [DW-1:0] sat33(input logic signed [DW:0] v);
        if (v[DW] != v[DW-1])
            sat33 = v[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        else
            sat33 = v[DW-1:0];
    endfunction

    assign out_valid = v2_reg;
    assign out_ctl   = c2_reg;
    assign num_re    = n_re_reg;
    assign num_im    = n_im_reg;
    assign den       = den_reg;
    assign simple_re = sat33(s2_re_reg);
    assign simple_im = sat33(s2_im_reg);
endmodule
`default_nettype wire

// File: rtl/cau_div.sv
// Pipelined restoring divider: one quotient bit per stage, saturated signed result.
`default_nettype none
module cau_div #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    input  wire logic signed [cau_pkg::SUM_W-1:0]    num,
    input  wire logic        [cau_pkg::DEN_W-1:0]    den,
    output logic                                     out_valid,
    output logic signed [cau_pkg::DATA_W-1:0]        quo
);
    localparam int unsigned DW  = cau_pkg::DATA_W;
    localparam int unsigned SW  = cau_pkg::SUM_W;
    localparam int unsigned NW  = SW - 1 + FRAC_BITS;   // scaled magnitude width
    localparam int unsigned QB  = DW;                   // quotient bits kept (+1 ovf)
    localparam int unsigned STG = QB + 1;
    localparam int unsigned RW  = cau_pkg::DEN_W + 1;
    localparam int unsigned HI  = NW - STG;             // bits whose quotient must be zero

    logic [NW-1:0] mag_next;
    logic          neg_next;
    logic          ovf_next;

    always_comb
    begin
        logic [SW-1:0] m;
        m = num[SW-1] ? SW'(-num) : num;
        mag_next = {m[SW-2:0], {FRAC_BITS{1'b0}}};
        neg_next = num[SW-1];
        ovf_next = 1'b0;
    end

    // Stage 0: split off the high part and check it against den (quotient too big).
    logic                 v0_reg, n0_reg, o0_reg;
    logic [NW-1:0]        m0_reg;
    logic [cau_pkg::DEN_W-1:0] d0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        m0_reg <= mag_next;
        n0_reg <= neg_next;
        o0_reg <= ovf_next;
        d0_reg <= den;
    end

    // Overflow when magnitude >> STG bits ≥ den.
    logic hi_ovf;
    assign hi_ovf = (cau_pkg::DEN_W'(m0_reg[NW-1:STG]) >= d0_reg);

    logic              v_reg [STG+1];
    logic              n_reg [STG+1];
    logic              o_reg [STG+1];
    logic [RW-1:0]     r_reg [STG+1];
    logic [STG-1:0]    lo_reg[STG+1];
    logic [STG-1:0]    q_reg [STG+1];
    logic [cau_pkg::DEN_W-1:0] dd_reg[STG+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        n_reg[0]  <= n0_reg;
        o_reg[0]  <= o0_reg | hi_ovf;
        r_reg[0]  <= hi_ovf ? '0 : RW'(m0_reg[NW-1:STG]);
        lo_reg[0] <= m0_reg[STG-1:0];
        q_reg[0]  <= '0;
        dd_reg[0] <= d0_reg;
    end

    for (genvar s = 0; s < STG; s++)
    begin : g_stage
        logic [RW-1:0] sh;
        logic          ge;
        assign sh = {r_reg[s][RW-2:0], lo_reg[s][STG-1]};
        assign ge = (sh >= RW'(dd_reg[s]));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s+1] <= 1'b0;
            else
                v_reg[s+1] <= v_reg[s];
        end

        always_ff @(posedge clk)
        begin
            n_reg[s+1]  <= n_reg[s];
            o_reg[s+1]  <= o_reg[s];
            dd_reg[s+1] <= dd_reg[s];
            lo_reg[s+1] <= {lo_reg[s][STG-2:0], 1'b0};
            r_reg[s+1]  <= ge ? (sh - RW'(dd_reg[s])) : sh;
            q_reg[s+1]  <= {q_reg[s][STG-2:0], ge};
        end
    end

    logic [STG-1:0] qf;
    logic           big;
    logic signed [DW-1:0] res_next;
    logic signed [DW-1:0] res_reg;
    logic                 vo_reg;
    assign qf = q_reg[STG];

    always_comb
    begin
        if (!n_reg[STG])
        begin
            big = o_reg[STG] | qf[STG-1] | qf[STG-2];
            res_next = big ? {1'b0, {(DW-1){1'b1}}} : qf[DW-1:0];
        end
        else
        begin
            big = o_reg[STG] | qf[STG-1] | (qf[STG-2] & |qf[STG-3:0]);
            res_next = big ? {1'b1, {(DW-1){1'b0}}} : -qf[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else
            vo_reg <= v_reg[STG];
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = vo_reg;
    assign quo       = res_reg;
endmodule
`default_nettype wire
